// ===== rtl/lqs_pkg.sv =====
// shared types, constants and command/status structs for the linear queue with search
package lqs_pkg;

  localparam int DEPTH  = 128;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CAP_W  = 8;
  localparam int EFF_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int DATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(128);

  localparam logic [1:0] ACT_ENQ  = 2'd0;
  localparam logic [1:0] ACT_DEQ  = 2'd1;
  localparam logic [1:0] ACT_SRCH = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_CMP  = 3'b100
  } state_t;

  typedef struct packed {
    logic take;
    logic rd;
    logic cmp;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
    logic scan_needed;
    logic match;
    logic last;
  } stat_t;

endpackage

// ===== rtl/lqs_ctrl.sv =====
// controller state machine sequencing single-beat actions and the search walk
module lqs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lqs_pkg::stat_t stat,
  output lqs_pkg::cmd_t  cmd
);

  lqs_pkg::state_t state;
  lqs_pkg::state_t state_next;

  assign in_ready = (state == lqs_pkg::S_IDLE) && !stat.out_busy && !rst;

  always_comb begin
    cmd.take   = in_valid && in_ready;
    cmd.rd     = (state == lqs_pkg::S_READ);
    cmd.cmp    = (state == lqs_pkg::S_CMP);
    state_next = state;
    unique case (state)
      lqs_pkg::S_IDLE: begin
        if (cmd.take && stat.scan_needed) begin
          state_next = lqs_pkg::S_READ;
        end
      end
      lqs_pkg::S_READ: begin
        state_next = lqs_pkg::S_CMP;
      end
      lqs_pkg::S_CMP: begin
        if (stat.match || stat.last) begin
          state_next = lqs_pkg::S_IDLE;
        end else begin
          state_next = lqs_pkg::S_READ;
        end
      end
      default: begin
        state_next = lqs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lqs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/lqs_dp.sv =====
// datapath: slot memory, head/tail pointers, capacity register, search compare, result register
module lqs_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  lqs_pkg::cmd_t                     cmd,
  output lqs_pkg::stat_t                    stat,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [lqs_pkg::CAP_W-1:0]         cfg_data,
  input  logic [1:0]                        action,
  input  logic signed [lqs_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic                              found,
  output logic                              is_empty,
  output logic                              is_full
);

  function automatic logic [lqs_pkg::EFF_W-1:0] eff_cap(input logic [lqs_pkg::CAP_W-1:0] c);
    logic [lqs_pkg::EFF_W-1:0] e;
    e = lqs_pkg::EFF_W'(c);
    if (c == '0) begin
      e = lqs_pkg::EFF_W'(1);
    end else if (e > lqs_pkg::EFF_W'(lqs_pkg::DEPTH)) begin
      e = lqs_pkg::EFF_W'(lqs_pkg::DEPTH);
    end
    return e;
  endfunction

  logic [lqs_pkg::DATA_W-1:0] mem [lqs_pkg::DEPTH];
  logic [lqs_pkg::DATA_W-1:0] rdata;
  logic [lqs_pkg::DATA_W-1:0] key;
  logic [lqs_pkg::ADDR_W-1:0] ptr;
  logic [lqs_pkg::CNT_W-1:0]  head;
  logic [lqs_pkg::CNT_W-1:0]  tail;
  logic [lqs_pkg::EFF_W-1:0]  cap;

  logic [lqs_pkg::CNT_W-1:0]  head_next;
  logic [lqs_pkg::CNT_W-1:0]  tail_next;
  logic [1:0]                 st;
  logic                       wr;
  logic                       empty_now;
  logic                       full_now;
  logic                       empty_after;
  logic                       full_after;

  always_comb begin
    empty_now = head >= tail;
    full_now  = lqs_pkg::EFF_W'(tail) >= cap;
    head_next = head;
    tail_next = tail;
    st        = lqs_pkg::ST_DONE;
    wr        = 1'b0;
    if (cmd.take) begin
      case (action)
        lqs_pkg::ACT_ENQ: begin
          if (full_now) begin
            st = lqs_pkg::ST_FULL;
          end else begin
            wr        = 1'b1;
            tail_next = tail + lqs_pkg::CNT_W'(1);
          end
        end
        lqs_pkg::ACT_DEQ: begin
          if (empty_now) begin
            st = lqs_pkg::ST_EMPTY;
          end else begin
            head_next = head + lqs_pkg::CNT_W'(1);
          end
        end
        lqs_pkg::ACT_SRCH: begin
          if (empty_now) begin
            st = lqs_pkg::ST_EMPTY;
          end
        end
        default: begin
        end
      endcase
    end
    empty_after = head_next >= tail_next;
    full_after  = lqs_pkg::EFF_W'(tail_next) >= cap;
  end

  assign stat.out_busy    = out_valid && !out_ready;
  assign stat.scan_needed = (action == lqs_pkg::ACT_SRCH) && !empty_now;
  assign stat.match       = (rdata == key);
  assign stat.last        = (lqs_pkg::CNT_W'(ptr) + lqs_pkg::CNT_W'(1)) >= tail;

  // slot memory
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[tail[lqs_pkg::ADDR_W-1:0]] <= value;
    end
    if (cmd.rd) begin
      rdata <= mem[ptr];
    end
  end

  // search walk
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      key <= value;
      ptr <= head[lqs_pkg::ADDR_W-1:0];
    end else if (cmd.cmp && !stat.match && !stat.last) begin
      ptr <= ptr + lqs_pkg::ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      cap  <= eff_cap(lqs_pkg::CAP_RESET);
    end else begin
      head <= head_next;
      tail <= tail_next;
      if (cfg_valid && cfg_ready) begin
        cap <= eff_cap(cfg_data);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.take && !stat.scan_needed) begin
      out_valid <= 1'b1;
    end else if (cmd.cmp && (stat.match || stat.last)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && !stat.scan_needed) begin
      status   <= st;
      found    <= 1'b0;
      is_empty <= empty_after;
      is_full  <= full_after;
    end else if (cmd.cmp && (stat.match || stat.last)) begin
      status   <= lqs_pkg::ST_DONE;
      found    <= stat.match;
      is_empty <= empty_now;
      is_full  <= full_now;
    end
  end

endmodule

// ===== rtl/linear_array_queue_with_search.sv =====
// top level of the linear queue with search: controller and datapath
// Linear (non-reusing) queue of signed 32-bit values, 128 slots. Each input beat
// carries one action: enqueue, dequeue or search; every action returns one result
// beat with status, found and the empty/full flags after the action. Enqueue,
// dequeue, the unused action code and any search on an empty queue give their
// result in the cycle after the input beat is taken. A search on a non-empty queue
// walks the slot memory from head toward tail through its single registered read
// port, reading and then comparing each entry, until it finds a match or the tail;
// at most 128 entries are examined. Slots freed by dequeue are not reused: once the
// tail reaches capacity the queue stays full until reset or a larger capacity is
// written. One action is in flight at a time; the next input beat is taken once the
// previous result has been or is being taken. The capacity register (8 bits, reset
// 128, zero acts as 1, values above 128 saturate) must be written by the user over
// the cfg channel only while the block is idle; the block does not enforce this.
module linear_array_queue_with_search (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lqs_pkg::CAP_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        action,
  input  logic signed [lqs_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic                              found,
  output logic                              is_empty,
  output logic                              is_full
);

  lqs_pkg::cmd_t  cmd;
  lqs_pkg::stat_t stat;

  assign cfg_ready = !rst;

  lqs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lqs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .action    (action),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .found     (found),
    .is_empty  (is_empty),
    .is_full   (is_full)
  );

endmodule
